>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked checks with reset qualification.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RNF_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rnf check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RNF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rnf check failed");

`endif

>>> src/rnf_pkg.sv
// ---------------------------------------------------------------------------
// rnf_pkg
// Shared types, widths and codes for the radius neighbour finder.
// ---------------------------------------------------------------------------
package rnf_pkg;

    localparam int MAX_NODES_DEF = 32;

    localparam int LABEL_W    = 16;
    localparam int COORD_W    = 16;
    localparam int NODE_IDX_W = 5;
    localparam int COUNT_W    = 6;
    localparam int RADIUS_W   = 36;
    localparam int CFG_IDX_W  = 2;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ  = 2'd1;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } point_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOADJ,
        ST_SCAN,
        ST_FINISH
    } rnf_state_t;

endpackage

>>> src/radius_neighbor_finder_top.sv
// ---------------------------------------------------------------------------
// radius_neighbor_finder_top
// Fixed-radius near-neighbour finder over a small store of 2-D points.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): each transfer carries one item. A write item
//   (s_func = 0) stores label and coordinates at s_node_index and gives no
//   result; the block is ready again at once. A query
//   item (s_func = 1) scans indices node_count-1 down to 0, skipping the
//   queried node, and emits one result per point with squared distance
//   <= radius_sq, highest index first. m_last marks the final result; a query
//   with no neighbour gives one result with m_neighbor_valid low.
//   Busy time: a query holds s_ready low through the load of the queried
//   point, one read per scanned index (node_count saturated at MAX_NODES),
//   three stages to drain, a check that the pipeline is empty and the load
//   of the final result. Each stall of the output register lengthens it. A
//   query outside the point count goes straight to loading its result.
//   Configuration (cfg_*): write node_count and radius_sq only while idle.
//   Reset: aresetn low clears control state, node_count to 1 and radius_sq to
//   0. Stored points are undefined until written; no clearing pass is run.
//   Stall: when a result waits with m_ready low the output register holds it
//   and the whole scan pipeline, including the memory read, freezes in place.
// ---------------------------------------------------------------------------
module radius_neighbor_finder_top #(
    parameter int MAX_NODES = rnf_pkg::MAX_NODES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [rnf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rnf_pkg::RADIUS_W-1:0]      cfg_wdata,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic [rnf_pkg::NODE_IDX_W-1:0]    s_node_index,
    input  logic [rnf_pkg::LABEL_W-1:0]       s_node_label,
    input  logic signed [rnf_pkg::COORD_W-1:0] s_pos_x,
    input  logic signed [rnf_pkg::COORD_W-1:0] s_pos_y,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rnf_pkg::LABEL_W-1:0]       m_query_label,
    output logic [rnf_pkg::NODE_IDX_W-1:0]    m_neighbor_index,
    output logic                              m_neighbor_valid,
    output logic                              m_last
);
    import rnf_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    // Control state
    rnf_state_t          state_reg, state_next;
    logic [COUNT_W-1:0]  node_count_reg;
    logic [RADIUS_W-1:0] radius_sq_reg;

    // Queried point
    logic [IDX_W-1:0]    j_reg;
    logic [LABEL_W-1:0]  qlabel_reg;
    logic [COORD_W-1:0]  xj_reg;
    logic [COORD_W-1:0]  yj_reg;

    // Scan pipeline: issue, read data, differences, squares
    logic [IDX_W-1:0]    idx_reg;
    logic                issue_reg;
    logic                v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]    i1_reg, i2_reg, i3_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]     dxsq_reg, dysq_reg;

    // One hit held back so that the final one can carry last
    logic                pend_valid_reg;
    logic [IDX_W-1:0]    pend_idx_reg;

    // Output register
    logic                   m_valid_reg, m_valid_next;
    logic [LABEL_W-1:0]     m_query_label_reg;
    logic [NODE_IDX_W-1:0]  m_neighbor_index_reg;
    logic                   m_neighbor_valid_reg;
    logic                   m_last_reg;

    // Combinational control
    logic                accept, query_acc, write_acc;
    logic                q_in_range, wr_in_range;
    logic [CNT_W-1:0]    count_eff;
    logic                out_free, scan_adv, pipe_empty;
    logic                mem_we, mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    point_t              wr_point, rd_point;
    logic signed [SQ_W-1:0]   dxsq_full, dysq_full;
    logic [SQ_W:0]       dist_sum;
    logic                hit;
    logic                out_load_mid, out_load_fin;

    // ------------------------------------------------------------------
    // Effective point count: saturate at the store depth
    // ------------------------------------------------------------------
    always_comb begin
        if (node_count_reg > COUNT_W'(MAX_NODES)) begin
            count_eff = CNT_W'(MAX_NODES);
        end else begin
            count_eff = node_count_reg[CNT_W-1:0];
        end
    end

    assign accept      = s_valid && s_ready;
    assign query_acc   = accept && (s_func == FUNC_QUERY);
    assign write_acc   = accept && (s_func == FUNC_WRITE);
    assign q_in_range  = {1'b0, s_node_index} < COUNT_W'(count_eff);
    assign wr_in_range = {1'b0, s_node_index} < COUNT_W'(MAX_NODES);

    assign out_free   = !m_valid_reg || m_ready;
    assign pipe_empty = !issue_reg && !v1_reg && !v2_reg && !v3_reg;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (query_acc) begin
                    state_next = q_in_range ? ST_LOADJ : ST_FINISH;
                end
            end
            ST_LOADJ: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (pipe_empty) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: handshake, memory access, pipeline advance
    // ------------------------------------------------------------------
    always_comb begin
        s_ready      = 1'b0;
        scan_adv     = 1'b0;
        out_load_fin = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_LOADJ: begin
                s_ready = 1'b0;
            end
            ST_SCAN: begin
                scan_adv = out_free;
            end
            ST_FINISH: begin
                out_load_fin = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Writes land only while idle, so a query never overlaps a write
    assign mem_we    = write_acc && wr_in_range;
    assign mem_re    = (query_acc && q_in_range) || (scan_adv && issue_reg);
    assign mem_raddr = (state_reg == ST_SCAN) ? idx_reg : s_node_index[IDX_W-1:0];

    assign wr_point.label = s_node_label;
    assign wr_point.x     = s_pos_x;
    assign wr_point.y     = s_pos_y;

    rnf_point_mem #(
        .DEPTH (MAX_NODES),
        .AW    (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (s_node_index[IDX_W-1:0]),
        .wr_data (wr_point),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (rd_point)
    );

    // ------------------------------------------------------------------
    // Distance datapath
    // ------------------------------------------------------------------
    assign dxsq_full = SQ_W'(dx_reg) * SQ_W'(dx_reg);
    assign dysq_full = SQ_W'(dy_reg) * SQ_W'(dy_reg);
    assign dist_sum  = {1'b0, dxsq_reg} + {1'b0, dysq_reg};
    assign hit       = v3_reg && (RADIUS_W'(dist_sum) <= radius_sq_reg);

    // A new hit pushes the held one out as a non-final result
    assign out_load_mid = scan_adv && hit && pend_valid_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= COUNT_W'(1);
            radius_sq_reg  <= '0;
            issue_reg      <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_NODE_COUNT: node_count_reg <= cfg_wdata[COUNT_W-1:0];
                    REG_RADIUS_SQ:  radius_sq_reg  <= cfg_wdata;
                    default:        ;
                endcase
            end

            if (query_acc) begin
                pend_valid_reg <= 1'b0;
            end else if (scan_adv && hit) begin
                pend_valid_reg <= 1'b1;
            end

            if (state_reg == ST_LOADJ) begin
                issue_reg <= 1'b1;
            end else if (scan_adv && issue_reg && (idx_reg == '0)) begin
                issue_reg <= 1'b0;
            end

            if (scan_adv) begin
                v1_reg <= issue_reg && (idx_reg != j_reg);
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge aclk) begin
        if (query_acc) begin
            j_reg <= s_node_index[IDX_W-1:0];
            if (!q_in_range) begin
                qlabel_reg <= '0;
            end
        end

        if (state_reg == ST_LOADJ) begin
            qlabel_reg <= rd_point.label;
            xj_reg     <= rd_point.x;
            yj_reg     <= rd_point.y;
            idx_reg    <= IDX_W'(count_eff - CNT_W'(1));
        end else if (scan_adv && issue_reg && (idx_reg != '0)) begin
            idx_reg <= idx_reg - IDX_W'(1);
        end

        if (scan_adv) begin
            i1_reg   <= idx_reg;
            i2_reg   <= i1_reg;
            dx_reg   <= DIFF_W'($signed(rd_point.x)) - DIFF_W'($signed(xj_reg));
            dy_reg   <= DIFF_W'($signed(rd_point.y)) - DIFF_W'($signed(yj_reg));
            i3_reg   <= i2_reg;
            dxsq_reg <= $unsigned(dxsq_full);
            dysq_reg <= $unsigned(dysq_full);
        end

        if (scan_adv && hit) begin
            pend_idx_reg <= i3_reg;
        end

        if (out_load_mid) begin
            m_query_label_reg    <= qlabel_reg;
            m_neighbor_index_reg <= NODE_IDX_W'(pend_idx_reg);
            m_neighbor_valid_reg <= 1'b1;
            m_last_reg           <= 1'b0;
        end else if (out_load_fin) begin
            m_query_label_reg    <= qlabel_reg;
            m_neighbor_index_reg <= pend_valid_reg ? NODE_IDX_W'(pend_idx_reg) : '0;
            m_neighbor_valid_reg <= pend_valid_reg;
            m_last_reg           <= 1'b1;
        end
    end

    // Fill the output register on a load, drain it on a transfer
    always_comb begin
        if (out_load_mid || out_load_fin) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_query_label    = m_query_label_reg;
    assign m_neighbor_index = m_neighbor_index_reg;
    assign m_neighbor_valid = m_neighbor_valid_reg;
    assign m_last           = m_last_reg;

endmodule

>>> src/rnf_point_mem.sv
// ---------------------------------------------------------------------------
// rnf_point_mem
// Point store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rnf_point_mem #(
    parameter int DEPTH = rnf_pkg::MAX_NODES_DEF,
    parameter int AW    = $clog2(rnf_pkg::MAX_NODES_DEF)
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  rnf_pkg::point_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output rnf_pkg::point_t rd_data
);
    import rnf_pkg::*;

    point_t mem [DEPTH];
    point_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the read word while the reader stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/rnf_checker.sv
// ---------------------------------------------------------------------------
// rnf_checker
// Port-level checks for the radius neighbour finder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rnf_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_wr_en,
    input logic [rnf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [rnf_pkg::RADIUS_W-1:0]       cfg_wdata,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               s_func,
    input logic [rnf_pkg::NODE_IDX_W-1:0]     s_node_index,
    input logic [rnf_pkg::LABEL_W-1:0]        s_node_label,
    input logic signed [rnf_pkg::COORD_W-1:0] s_pos_x,
    input logic signed [rnf_pkg::COORD_W-1:0] s_pos_y,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [rnf_pkg::LABEL_W-1:0]        m_query_label,
    input logic [rnf_pkg::NODE_IDX_W-1:0]     m_neighbor_index,
    input logic                               m_neighbor_valid,
    input logic                               m_last
);
    import rnf_pkg::*;

    // Stalled result holds
    `RNF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable({m_query_label, m_neighbor_index, m_neighbor_valid, m_last}))

    // An empty list is always a single, final result with index zero
    `RNF_ASSERT_SAME(a_empty_last, aclk, aresetn, m_valid && !m_neighbor_valid, m_last && (m_neighbor_index == '0))

    // A query occupies the block: no transfer in the following cycle
    `RNF_ASSERT_NEXT(a_query_busy, aclk, aresetn, s_valid && s_ready && (s_func == FUNC_QUERY), !s_ready)

    // A point write leaves the block ready
    `RNF_ASSERT_NEXT(a_write_ready, aclk, aresetn, s_valid && s_ready && (s_func == FUNC_WRITE), s_ready)

endmodule

bind radius_neighbor_finder_top rnf_checker u_rnf_checker (.*);
